// ----- src/ams_pkg.sv -----
// Shared types and constants for the affine mask sampler.
package ams_pkg;

    localparam int COEF_W     = 24;
    localparam int OFF_W      = 32;
    localparam int DIM_W      = 13;
    localparam int PIX_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int UX_W       = PIX_W + 1;
    localparam int PROD_W     = COEF_W + UX_W + 1;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FLOOR_SH   = 17;
    localparam int INT_W      = SUM_W - FLOOR_SH;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_W     = 2 * BYTE_W;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_W = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_H = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd65536;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [OFF_W-1:0]  t_off;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] idx;
    } t_axis_res;

endpackage

// ----- src/ams_axis.sv -----
// One document axis: two products, sum with offset, range check and floor.
module ams_axis #(
    parameter int LIMIT = 256
) (
    input  logic                  i_clk,
    input  logic [ams_pkg::UX_W-1:0] i_ux,
    input  logic [ams_pkg::UX_W-1:0] i_uy,
    input  ams_pkg::t_coef         i_coef_a,
    input  ams_pkg::t_coef         i_coef_b,
    input  ams_pkg::t_off          i_offset,
    output ams_pkg::t_axis_res     o_res
);
    import ams_pkg::*;

    localparam logic [INT_W-1:0] LIM = INT_W'(LIMIT);

    logic signed [UX_W:0]     ux_s;
    logic signed [UX_W:0]     uy_s;
    logic signed [PROD_W-1:0] n_pa;
    logic signed [PROD_W-1:0] n_pb;
    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;
    logic signed [OFF_W:0]    off2;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  r_sum;
    t_axis_res                n_res;
    t_axis_res                r_res;

    assign ux_s = $signed({1'b0, i_ux});
    assign uy_s = $signed({1'b0, i_uy});
    assign n_pa = PROD_W'(i_coef_a) * PROD_W'(ux_s);
    assign n_pb = PROD_W'(i_coef_b) * PROD_W'(uy_s);
    assign off2 = $signed({i_offset, 1'b0});

    assign n_sum = SUM_W'(r_pa) + SUM_W'(r_pb) + SUM_W'(off2);

    always_comb begin
        n_res.hit = !r_sum[SUM_W-1] && (r_sum[SUM_W-1:FLOOR_SH] < LIM);
        n_res.idx = r_sum[FLOOR_SH+BYTE_W-1:FLOOR_SH];
    end

    always_ff @(posedge i_clk) begin
        r_pa  <= n_pa;
        r_pb  <= n_pb;
        r_sum <= n_sum;
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- src/affine_mask_sampler.sv -----
// Affine mask sampler: pipelined nearest-neighbour mask lookup through an affine map.
// A sample item passes the input registers, the axis product, sum and result registers, then the output registers.
// Throughput: one item per cycle; busy stays low, so start is never refused.
// A write item stores its byte in the same stage that samples read the mask store.
// Synchronous active-low reset clears the valid bits, sets the transform to identity and zeroes the target size.
// The mask store has no reset; an entry reads as garbage until written.
module affine_mask_sampler #(
    parameter int MASK_W = 256,
    parameter int MASK_H = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_func,
    input  logic [ams_pkg::BYTE_W-1:0]       i_mask_col,
    input  logic [ams_pkg::BYTE_W-1:0]       i_mask_row,
    input  logic [ams_pkg::BYTE_W-1:0]       i_mask_byte,
    input  logic [ams_pkg::PIX_W-1:0]        i_pixel_x,
    input  logic [ams_pkg::PIX_W-1:0]        i_pixel_y,
    input  logic                             i_cfg_we,
    input  logic [ams_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ams_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_valid,
    output logic [ams_pkg::BYTE_W-1:0]       o_coverage,
    output logic                             o_inside_res
);
    import ams_pkg::*;

    localparam int DEPTH = 4;

    typedef struct packed {
        logic              func;
        logic              pass;
        logic [BYTE_W-1:0] col;
        logic [BYTE_W-1:0] row;
        logic [BYTE_W-1:0] data;
    } t_ctl;

    t_coef             r_coef_xx;
    t_coef             r_coef_xy;
    t_coef             r_coef_yx;
    t_coef             r_coef_yy;
    t_off              r_offset_x;
    t_off              r_offset_y;
    logic [DIM_W-1:0]  r_target_w;
    logic [DIM_W-1:0]  r_target_h;

    logic              accept;
    t_ctl              n_ctl;
    logic [DEPTH-1:0]  r_vld;
    t_ctl              r_ctl [DEPTH];
    logic [UX_W-1:0]   r_ux;
    logic [UX_W-1:0]   r_uy;
    t_axis_res         res_x;
    t_axis_res         res_y;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] r_mask_mem [2**ADDR_W];
    logic [BYTE_W-1:0] r_rd;
    logic              r_out_vld;
    logic              r_out_in;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx  <= COEF_ONE;
            r_coef_xy  <= '0;
            r_coef_yx  <= '0;
            r_coef_yy  <= COEF_ONE;
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_target_w <= '0;
            r_target_h <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_XX:  r_coef_xx  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_XY:  r_coef_xy  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_YX:  r_coef_yx  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_YY:  r_coef_yy  <= i_cfg_data[COEF_W-1:0];
                CFG_OFFSET_X: r_offset_x <= i_cfg_data[OFF_W-1:0];
                CFG_OFFSET_Y: r_offset_y <= i_cfg_data[OFF_W-1:0];
                CFG_TARGET_W: r_target_w <= i_cfg_data[DIM_W-1:0];
                CFG_TARGET_H: r_target_h <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ctl.func = i_func;
        n_ctl.pass = ({1'b0, i_pixel_x} < r_target_w) && ({1'b0, i_pixel_y} < r_target_h);
        n_ctl.col  = i_mask_col;
        n_ctl.row  = i_mask_row;
        n_ctl.data = i_mask_byte;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[DEPTH-2:0], accept};
            r_out_vld <= r_vld[DEPTH-1] && (r_ctl[DEPTH-1].func == FUNC_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl[0] <= n_ctl;
        for (int i = 1; i < DEPTH; i++) begin
            r_ctl[i] <= r_ctl[i-1];
        end
        r_ux <= {i_pixel_x, 1'b1};
        r_uy <= {i_pixel_y, 1'b1};
    end

    ams_axis #(.LIMIT(MASK_W)) u_axis_x (
        .i_clk    (i_clk),
        .i_ux     (r_ux),
        .i_uy     (r_uy),
        .i_coef_a (r_coef_xx),
        .i_coef_b (r_coef_xy),
        .i_offset (r_offset_x),
        .o_res    (res_x)
    );

    ams_axis #(.LIMIT(MASK_H)) u_axis_y (
        .i_clk    (i_clk),
        .i_ux     (r_ux),
        .i_uy     (r_uy),
        .i_coef_a (r_coef_yx),
        .i_coef_b (r_coef_yy),
        .i_offset (r_offset_y),
        .o_res    (res_y)
    );

    assign mem_we   = r_vld[DEPTH-1] && (r_ctl[DEPTH-1].func == FUNC_WRITE);
    assign mem_addr = (r_ctl[DEPTH-1].func == FUNC_WRITE) ?
                      {r_ctl[DEPTH-1].row, r_ctl[DEPTH-1].col} : {res_y.idx, res_x.idx};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mask_mem[mem_addr] <= r_ctl[DEPTH-1].data;
        end
        r_rd     <= r_mask_mem[mem_addr];
        r_out_in <= r_ctl[DEPTH-1].pass && res_x.hit && res_y.hit;
    end

    assign o_valid      = r_out_vld;
    assign o_inside_res = r_out_in;
    assign o_coverage   = r_out_in ? r_rd : '0;

endmodule

// ----- src/ams_chk.sv -----
// Port-level checker for the affine mask sampler, bound to the top level.
module ams_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            i_func,
    input logic                            o_valid,
    input logic [ams_pkg::BYTE_W-1:0]      o_coverage,
    input logic                            o_inside_res
);
    import ams_pkg::*;

    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_SAMPLE)) |-> ##5 o_valid)
        else $error("sample item gave no result");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_WRITE)) |-> ##5 !o_valid)
        else $error("write item gave a result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_func == FUNC_SAMPLE), 5))
        else $error("result without a sample item");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_res) |-> (o_coverage == '0))
        else $error("coverage not zero outside the mask");

endmodule

bind affine_mask_sampler ams_chk u_ams_chk (.*);
